// ===== rtl/core/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
   typedef enum logic [3:0] {
      FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3, FN_NEG = 4'd4,
      FN_LT = 4'd5, FN_LE = 4'd6, FN_GT = 4'd7, FN_GE = 4'd8, FN_EQ = 4'd9,
      FN_NE = 4'd10
   } func_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2, ST_OVERFLOW = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_GCD_A, S_DIVN_A, S_DIVD_A, S_GCD_B, S_DIVN_B, S_DIVD_B,
      S_PREP, S_GCD_L, S_DIV_L, S_MUL_L, S_DIV_LA, S_MUL_T1, S_DIV_LB,
      S_MUL_T2, S_ADD, S_MUL_P1, S_MUL_P2, S_CMP, S_GCD_R, S_DIVN_R, S_DIVD_R,
      S_CHECK, S_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/rau_divider.sv =====
`default_nettype none
// Shared radix-2 restoring divider on 64-bit unsigned values, one quotient bit a cycle.
module rau_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             busy,
   output logic [63:0]      quotient,
   output logic [63:0]      remainder
);
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy      = (cnt_ff != 7'd0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
`default_nettype none
// Channel  Dir  Fields (low bit up)
// req      in   tdata: func[3:0] a_num[35:4] a_den[67:36] b_num[99:68] b_den[131:100]
// rsp      out  tdata: res_num[31:0] res_den[62:32] cmp_true[63]; tuser: status[1:0]
// One request at a time; every Euclid step and every divide by a gcd uses the
// shared 64-bit serial divider. A zero denominator or unused code goes from the
// load state straight to the done state; other items run the Euclid and divide
// steps. Each multiply is one combinational 32x32 product (low operand bits).
// Reset is synchronous; req_tready stays low until the result is taken.
module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // func, a_num, a_den, b_num, b_den
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // res_num, res_den, cmp_true
   output logic [1:0]        rsp_tuser   // status
);
   localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

   rau_pkg::state_type state_ff, state_in;
   logic [3:0]  func_ff;
   logic [63:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic        aneg_ff, bneg_ff, rneg_ff;
   logic [63:0] am_ff, adn_ff, bm_ff, bdn_ff, rm_ff, rd_ff;
   logic [63:0] x_ff, y_ff, g_ff, l_ff, t1_ff, t2_ff;
   logic [1:0]  status_ff;
   logic        cmp_ff;
   logic [63:0] res_num_val;
   logic [30:0] res_den_val;
   logic        start, dbusy, dstarted_ff;
   logic [63:0] dvd, dvs, quo, rem;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   function automatic logic [63:0] sx(input logic [31:0] v);
      logic [63:0] r;
      r = 64'(signed'(v[WIDTH-1:0]));
      return r;
   endfunction

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd), .divisor(dvs),
      .busy(dbusy), .quotient(quo), .remainder(rem)
   );

   assign prod = 64'(mul_a) * 64'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::S_IDLE: if (req_tvalid) state_in = rau_pkg::S_LOAD;
         rau_pkg::S_LOAD: state_in = (status_ff != rau_pkg::ST_OK || func_ff > 4'd10) ?
                                     rau_pkg::S_DONE : rau_pkg::S_GCD_A;
         rau_pkg::S_GCD_A, rau_pkg::S_GCD_B, rau_pkg::S_GCD_L, rau_pkg::S_GCD_R: begin
            if (y_ff == 64'd0) begin
               case (state_ff)
                  rau_pkg::S_GCD_A: state_in = rau_pkg::S_DIVN_A;
                  rau_pkg::S_GCD_B: state_in = rau_pkg::S_DIVN_B;
                  rau_pkg::S_GCD_L: state_in = rau_pkg::S_DIV_L;
                  default:          state_in = rau_pkg::S_DIVN_R;
               endcase
            end
         end
         rau_pkg::S_DIVN_A, rau_pkg::S_DIVD_A, rau_pkg::S_DIVN_B, rau_pkg::S_DIVD_B,
         rau_pkg::S_DIV_L, rau_pkg::S_DIV_LA, rau_pkg::S_DIV_LB, rau_pkg::S_DIVN_R,
         rau_pkg::S_DIVD_R: begin
            if (dstarted_ff && !dbusy) begin
               case (state_ff)
                  rau_pkg::S_DIVN_A: state_in = rau_pkg::S_DIVD_A;
                  rau_pkg::S_DIVD_A: state_in = (func_ff == rau_pkg::FN_NEG) ?
                                                rau_pkg::S_PREP : rau_pkg::S_GCD_B;
                  rau_pkg::S_DIVN_B: state_in = rau_pkg::S_DIVD_B;
                  rau_pkg::S_DIVD_B: state_in = rau_pkg::S_PREP;
                  rau_pkg::S_DIV_L:  state_in = rau_pkg::S_MUL_L;
                  rau_pkg::S_DIV_LA: state_in = rau_pkg::S_MUL_T1;
                  rau_pkg::S_DIV_LB: state_in = rau_pkg::S_MUL_T2;
                  rau_pkg::S_DIVN_R: state_in = rau_pkg::S_DIVD_R;
                  default:           state_in = rau_pkg::S_CHECK;
               endcase
            end
         end
         rau_pkg::S_PREP: begin
            case (func_ff)
               rau_pkg::FN_ADD, rau_pkg::FN_SUB: state_in = rau_pkg::S_GCD_L;
               rau_pkg::FN_MUL, rau_pkg::FN_DIV: state_in = rau_pkg::S_MUL_P1;
               rau_pkg::FN_NEG:                  state_in = rau_pkg::S_CHECK;
               default:                          state_in = rau_pkg::S_MUL_P1;
            endcase
         end
         rau_pkg::S_MUL_L:  state_in = rau_pkg::S_DIV_LA;
         rau_pkg::S_MUL_T1: state_in = rau_pkg::S_DIV_LB;
         rau_pkg::S_MUL_T2: state_in = rau_pkg::S_ADD;
         rau_pkg::S_ADD:    state_in = rau_pkg::S_GCD_R;
         rau_pkg::S_MUL_P1: state_in = rau_pkg::S_MUL_P2;
         rau_pkg::S_MUL_P2: begin
            if (func_ff inside {[4'd5:4'd10]}) state_in = rau_pkg::S_CMP;
            else if (func_ff == rau_pkg::FN_DIV && bm_ff == 64'd0) state_in = rau_pkg::S_DONE;
            else state_in = rau_pkg::S_GCD_R;
         end
         rau_pkg::S_CMP:   state_in = rau_pkg::S_DONE;
         rau_pkg::S_CHECK: state_in = rau_pkg::S_DONE;
         rau_pkg::S_DONE:  if (rsp_tready) state_in = rau_pkg::S_IDLE;
         default:          state_in = rau_pkg::S_IDLE;
      endcase
   end

   // divider and multiplier operand selection
   always_comb begin
      start = 1'b0;
      dvd   = x_ff;
      dvs   = y_ff;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         rau_pkg::S_GCD_A, rau_pkg::S_GCD_B, rau_pkg::S_GCD_L, rau_pkg::S_GCD_R:
            start = (y_ff != 64'd0) && !dstarted_ff;
         rau_pkg::S_DIVN_A: begin start = !dstarted_ff; dvd = am_ff;  dvs = g_ff; end
         rau_pkg::S_DIVD_A: begin start = !dstarted_ff; dvd = adn_ff; dvs = g_ff; end
         rau_pkg::S_DIVN_B: begin start = !dstarted_ff; dvd = bm_ff;  dvs = g_ff; end
         rau_pkg::S_DIVD_B: begin start = !dstarted_ff; dvd = bdn_ff; dvs = g_ff; end
         rau_pkg::S_DIVN_R: begin start = !dstarted_ff; dvd = rm_ff;  dvs = g_ff; end
         rau_pkg::S_DIVD_R: begin start = !dstarted_ff; dvd = rd_ff;  dvs = g_ff; end
         rau_pkg::S_DIV_L:  begin start = !dstarted_ff; dvd = adn_ff; dvs = g_ff; end
         rau_pkg::S_DIV_LA: begin start = !dstarted_ff; dvd = l_ff; dvs = adn_ff; end
         rau_pkg::S_DIV_LB: begin start = !dstarted_ff; dvd = l_ff; dvs = bdn_ff; end
         rau_pkg::S_MUL_L:  begin mul_a = l_ff[31:0];  mul_b = bdn_ff[31:0]; end
         rau_pkg::S_MUL_T1: begin mul_a = am_ff[31:0]; mul_b = quo[31:0]; end
         rau_pkg::S_MUL_T2: begin mul_a = bm_ff[31:0]; mul_b = quo[31:0]; end
         rau_pkg::S_MUL_P1: begin
            mul_a = am_ff[31:0];
            mul_b = (func_ff == rau_pkg::FN_MUL) ? bm_ff[31:0] : bdn_ff[31:0];
         end
         rau_pkg::S_MUL_P2: begin
            mul_a = adn_ff[31:0];
            mul_b = (func_ff == rau_pkg::FN_MUL) ? bdn_ff[31:0] : bm_ff[31:0];
         end
         default: ;
      endcase
   end

   logic [63:0] mag_an, mag_ad, mag_bn, mag_bd;
   always_comb begin
      mag_an = an_ff[63] ? -an_ff : an_ff;
      mag_ad = ad_ff[63] ? -ad_ff : ad_ff;
      mag_bn = bn_ff[63] ? -bn_ff : bn_ff;
      mag_bd = bd_ff[63] ? -bd_ff : bd_ff;
   end

   logic s2;
   assign s2 = (func_ff == rau_pkg::FN_SUB) ? !bneg_ff : bneg_ff;

   // signed cross products for compares: a side in t1, b side in rd
   logic signed [64:0] cx, cy;
   logic               hold;
   always_comb begin
      cx = aneg_ff ? -$signed({1'b0, t1_ff}) : $signed({1'b0, t1_ff});
      cy = bneg_ff ? -$signed({1'b0, rd_ff}) : $signed({1'b0, rd_ff});
      case (func_ff)
         rau_pkg::FN_LT: hold = cx < cy;
         rau_pkg::FN_LE: hold = cx <= cy;
         rau_pkg::FN_GT: hold = cx > cy;
         rau_pkg::FN_GE: hold = cx >= cy;
         rau_pkg::FN_EQ: hold = cx == cy;
         default:        hold = cx != cy;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rau_pkg::S_IDLE;
         dstarted_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) dstarted_ff <= 1'b0;
         else if (start)           dstarted_ff <= 1'b1;
         else if (dstarted_ff && !dbusy &&
                  (state_ff == rau_pkg::S_GCD_A || state_ff == rau_pkg::S_GCD_B ||
                   state_ff == rau_pkg::S_GCD_L || state_ff == rau_pkg::S_GCD_R))
            dstarted_ff <= 1'b0;
      end
      case (state_ff)
         rau_pkg::S_IDLE: if (req_tvalid) begin
            func_ff   <= req_tdata[3:0];
            an_ff     <= sx(req_tdata[35:4]);
            ad_ff     <= sx(req_tdata[67:36]);
            bn_ff     <= sx(req_tdata[99:68]);
            bd_ff     <= sx(req_tdata[131:100]);
            cmp_ff    <= 1'b0;
            rneg_ff   <= 1'b0;
            rm_ff     <= '0;
            rd_ff     <= 64'd1;
            status_ff <= (sx(req_tdata[67:36]) == 64'd0 ||
                          (req_tdata[3:0] != rau_pkg::FN_NEG &&
                           sx(req_tdata[131:100]) == 64'd0)) &&
                         req_tdata[3:0] <= 4'd10 ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
         end
         rau_pkg::S_LOAD: begin
            am_ff   <= mag_an;
            adn_ff  <= (an_ff == 64'd0) ? 64'd1 : mag_ad;
            bm_ff   <= mag_bn;
            bdn_ff  <= (bn_ff == 64'd0) ? 64'd1 : mag_bd;
            aneg_ff <= (an_ff[63] != ad_ff[63]) && an_ff != 64'd0;
            bneg_ff <= (bn_ff[63] != bd_ff[63]) && bn_ff != 64'd0;
            x_ff <= mag_an;
            y_ff <= (an_ff == 64'd0) ? 64'd0 : mag_ad;
         end
         default: ;
      endcase
      // Euclid step: replace (x, y) by (y, x mod y)
      if ((state_ff == rau_pkg::S_GCD_A || state_ff == rau_pkg::S_GCD_B ||
           state_ff == rau_pkg::S_GCD_L || state_ff == rau_pkg::S_GCD_R)) begin
         if (y_ff == 64'd0) g_ff <= (x_ff == 64'd0) ? 64'd1 : x_ff;
         else if (dstarted_ff && !dbusy) begin
            x_ff <= y_ff;
            y_ff <= rem;
         end
      end
      if (dstarted_ff && !dbusy) begin
         case (state_ff)
            rau_pkg::S_DIVN_A: am_ff  <= quo;
            rau_pkg::S_DIVD_A: begin
               adn_ff <= quo;
               x_ff <= mag_bn;
               y_ff <= (bn_ff == 64'd0) ? 64'd0 : mag_bd;
            end
            rau_pkg::S_DIVN_B: bm_ff  <= quo;
            rau_pkg::S_DIVD_B: bdn_ff <= quo;
            rau_pkg::S_DIV_L:  l_ff   <= quo;
            rau_pkg::S_DIVN_R: rm_ff  <= quo;
            rau_pkg::S_DIVD_R: rd_ff  <= quo;
            default: ;
         endcase
      end
      case (state_ff)
         rau_pkg::S_PREP: begin
            x_ff <= adn_ff;
            y_ff <= bdn_ff;
            if (func_ff == rau_pkg::FN_NEG) begin
               rm_ff   <= am_ff;
               rd_ff   <= adn_ff;
               rneg_ff <= !aneg_ff && am_ff != 64'd0;
            end
         end
         rau_pkg::S_MUL_L:  begin l_ff <= prod; rd_ff <= prod; end
         rau_pkg::S_MUL_T1: t1_ff <= prod;
         rau_pkg::S_MUL_T2: t2_ff <= prod;
         rau_pkg::S_ADD: begin
            if (aneg_ff == s2) begin
               rm_ff <= t1_ff + t2_ff; rneg_ff <= aneg_ff;
            end else if (t1_ff >= t2_ff) begin
               rm_ff <= t1_ff - t2_ff; rneg_ff <= aneg_ff;
            end else begin
               rm_ff <= t2_ff - t1_ff; rneg_ff <= s2;
            end
         end
         rau_pkg::S_MUL_P1: begin t1_ff <= prod; rm_ff <= prod; end
         rau_pkg::S_MUL_P2: begin
            rd_ff   <= prod;
            rneg_ff <= aneg_ff != bneg_ff;
            if (func_ff == rau_pkg::FN_DIV && bm_ff == 64'd0)
               status_ff <= rau_pkg::ST_DIV_ZERO;
            x_ff <= t1_ff;
            y_ff <= (t1_ff == 64'd0) ? 64'd0 : prod;
         end
         rau_pkg::S_CMP: cmp_ff <= hold;
         rau_pkg::S_CHECK: begin
            // a zero result always reduces to 0/1 and cannot overflow
            if (rm_ff == 64'd0) begin rd_ff <= 64'd1; rneg_ff <= 1'b0; end
            if (rm_ff != 64'd0 &&
                (rd_ff > LIM - 64'd1 || rm_ff > (rneg_ff ? LIM : LIM - 64'd1)))
               status_ff <= rau_pkg::ST_OVERFLOW;
         end
         default: ;
      endcase
      // after S_ADD the gcd of the sum and lcm starts from (mag, den)
      if (state_ff == rau_pkg::S_ADD) begin
         x_ff <= (aneg_ff == s2) ? t1_ff + t2_ff :
                 (t1_ff >= t2_ff) ? t1_ff - t2_ff : t2_ff - t1_ff;
         y_ff <= ((aneg_ff == s2) ? t1_ff + t2_ff :
                  (t1_ff >= t2_ff) ? t1_ff - t2_ff : t2_ff - t1_ff) == 64'd0 ? 64'd0 : rd_ff;
      end
   end

   // output fields
   logic ok_arith;
   always_comb begin
      ok_arith    = status_ff == rau_pkg::ST_OK && func_ff <= 4'd4 && rm_ff != 64'd0;
      res_num_val = ok_arith ? (rneg_ff ? -rm_ff : rm_ff) : 64'd0;
      res_den_val = ok_arith ? rd_ff[30:0] : 31'd1;
   end

   assign req_tready = (state_ff == rau_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == rau_pkg::S_DONE);
   assign rsp_tdata  = {cmp_ff && status_ff == rau_pkg::ST_OK, res_den_val, res_num_val[31:0]};
   assign rsp_tuser  = status_ff;

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[62:32] != 31'd0) else $error("zero result denominator");
`endif
endmodule
`default_nettype wire
